// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the RTL file that checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, masked while reset is high.
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/ckh_pkg.sv =====
// Types, codes and constants of the cuckoo hash table.
`timescale 1ns / 1ps
package ckh_pkg;

  localparam int TABLE_LOG_MAX_DEF = 10;
  localparam int VALUE_BITS_DEF    = 32;

  localparam int KEY_BITS  = 32;
  localparam int DATA_BITS = 32;
  localparam int CNT_BITS  = 11;
  localparam int CFG_BITS  = 4;
  localparam int CMD_BITS  = 2;
  localparam int STAT_BITS = 3;

  localparam logic [CFG_BITS-1:0] CFG_RESET = 4'd10;
  localparam logic [31:0] MUL_A = 32'hF230D3A1;
  localparam logic [31:0] MUL_B = 32'h8084027F;

  localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_ERASE  = 2'd2;
  localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd3;

  localparam logic [STAT_BITS-1:0] ST_NEW       = 3'd0;
  localparam logic [STAT_BITS-1:0] ST_UPDATED   = 3'd1;
  localparam logic [STAT_BITS-1:0] ST_FOUND     = 3'd2;
  localparam logic [STAT_BITS-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STAT_BITS-1:0] ST_ERASED    = 3'd4;
  localparam logic [STAT_BITS-1:0] ST_CLEARED   = 3'd5;
  localparam logic [STAT_BITS-1:0] ST_FULL      = 3'd6;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_HASH, S_RD1, S_RD2, S_CHK, S_KRD, S_KCHK,
    S_KHASH, S_KPOS, S_CLR, S_CLRFIN, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    DP_NONE, DP_ACCEPT, DP_HASH, DP_RD1, DP_RD2, DP_DECIDE, DP_KRD,
    DP_KCHK, DP_KPOS, DP_CLR, DP_CLR_DONE, DP_EMIT
  } dp_op_t;

  typedef struct packed {
    logic [CMD_BITS-1:0] cmd;
    logic evict_need;
    logic kick_free;
    logic kicks_zero;
    logic clr_last;
    logic out_full;
  } dp_stat_t;

endpackage

// ===== hw/rtl/ckh_ctrl.sv =====
// Sequencer of the cuckoo hash table: walks each request through its steps.
`timescale 1ns / 1ps
module ckh_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  ckh_pkg::dp_stat_t stat,
  output ckh_pkg::dp_op_t  op
);

  ckh_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ckh_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ckh_pkg::S_INIT:   if (stat.clr_last) state_next = ckh_pkg::S_IDLE;
      ckh_pkg::S_IDLE:   if (s_tvalid) state_next = ckh_pkg::S_HASH;
      ckh_pkg::S_HASH: begin
        if (stat.cmd == ckh_pkg::CMD_CLEAR) state_next = ckh_pkg::S_CLR;
        else state_next = ckh_pkg::S_RD1;
      end
      ckh_pkg::S_RD1:    state_next = ckh_pkg::S_RD2;
      ckh_pkg::S_RD2:    state_next = ckh_pkg::S_CHK;
      ckh_pkg::S_CHK: begin
        if (stat.evict_need) state_next = ckh_pkg::S_KRD;
        else state_next = ckh_pkg::S_DONE;
      end
      ckh_pkg::S_KRD:    state_next = ckh_pkg::S_KCHK;
      ckh_pkg::S_KCHK: begin
        if (stat.kick_free || stat.kicks_zero) state_next = ckh_pkg::S_DONE;
        else state_next = ckh_pkg::S_KHASH;
      end
      ckh_pkg::S_KHASH:  state_next = ckh_pkg::S_KPOS;
      ckh_pkg::S_KPOS:   state_next = ckh_pkg::S_KRD;
      ckh_pkg::S_CLR:    if (stat.clr_last) state_next = ckh_pkg::S_CLRFIN;
      ckh_pkg::S_CLRFIN: state_next = ckh_pkg::S_DONE;
      ckh_pkg::S_DONE:   if (!stat.out_full) state_next = ckh_pkg::S_IDLE;
      default:           state_next = ckh_pkg::S_INIT;
    endcase
  end

  // Datapath commands
  always_comb begin
    op = ckh_pkg::DP_NONE;
    s_tready = 1'b0;
    unique case (state)
      ckh_pkg::S_INIT:   op = ckh_pkg::DP_CLR;
      ckh_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) op = ckh_pkg::DP_ACCEPT;
      end
      ckh_pkg::S_HASH:   op = ckh_pkg::DP_HASH;
      ckh_pkg::S_RD1:    op = ckh_pkg::DP_RD1;
      ckh_pkg::S_RD2:    op = ckh_pkg::DP_RD2;
      ckh_pkg::S_CHK:    op = ckh_pkg::DP_DECIDE;
      ckh_pkg::S_KRD:    op = ckh_pkg::DP_KRD;
      ckh_pkg::S_KCHK:   op = ckh_pkg::DP_KCHK;
      ckh_pkg::S_KHASH:  op = ckh_pkg::DP_HASH;
      ckh_pkg::S_KPOS:   op = ckh_pkg::DP_KPOS;
      ckh_pkg::S_CLR:    op = ckh_pkg::DP_CLR;
      ckh_pkg::S_CLRFIN: op = ckh_pkg::DP_CLR_DONE;
      ckh_pkg::S_DONE:   if (!stat.out_full) op = ckh_pkg::DP_EMIT;
      default:           op = ckh_pkg::DP_NONE;
    endcase
  end

endmodule

// ===== hw/rtl/ckh_datapath.sv =====
// Datapath of the cuckoo hash table: slot memory, hash multipliers, result register.
`timescale 1ns / 1ps
module ckh_datapath #(
  parameter int TABLE_LOG_MAX = ckh_pkg::TABLE_LOG_MAX_DEF,
  parameter int VALUE_BITS    = ckh_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ckh_pkg::CMD_BITS-1:0]  in_cmd,
  input  logic [ckh_pkg::KEY_BITS-1:0]  in_key,
  input  logic [ckh_pkg::DATA_BITS-1:0] in_value,
  input  logic                          cfg_valid,
  input  logic [ckh_pkg::CFG_BITS-1:0]  cfg_data,
  input  ckh_pkg::dp_op_t               op,
  output ckh_pkg::dp_stat_t             stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ckh_pkg::STAT_BITS-1:0] out_status,
  output logic [ckh_pkg::DATA_BITS-1:0] out_found,
  output logic [ckh_pkg::KEY_BITS-1:0]  out_ekey,
  output logic [ckh_pkg::DATA_BITS-1:0] out_evalue,
  output logic [ckh_pkg::CNT_BITS-1:0]  out_count
);

  localparam int SLOTS = 1 << TABLE_LOG_MAX;
  localparam int IW    = TABLE_LOG_MAX;
  localparam int CW    = TABLE_LOG_MAX + 1;
  localparam int LGW   = $clog2(TABLE_LOG_MAX + 1);
  localparam int SVW   = (VALUE_BITS < ckh_pkg::DATA_BITS) ? VALUE_BITS : ckh_pkg::DATA_BITS;
  localparam int KB    = ckh_pkg::KEY_BITS;
  localparam int WW    = 1 + KB + SVW;

  logic [WW-1:0] mem [SLOTS];
  logic [WW-1:0] rdata;
  logic [WW-1:0] d1;
  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [WW-1:0] wr_word;

  logic [ckh_pkg::CFG_BITS-1:0]  cfg_q;
  logic [LGW-1:0]                lg;
  logic [ckh_pkg::CMD_BITS-1:0]  cmd;
  logic [KB-1:0]                 key;
  logic [SVW-1:0]                val;
  logic [KB-1:0]                 hkey;
  logic [31:0]                   pa, pb;
  logic [31:0]                   fval;
  logic [IW-1:0]                 h1, h2;
  logic [IW-1:0]                 pos;
  logic [CW-1:0]                 kicks;
  logic [CW-1:0]                 count;
  logic [KB-1:0]                 ck;
  logic [SVW-1:0]                cv;
  logic [IW-1:0]                 clr_idx;

  logic [ckh_pkg::STAT_BITS-1:0] res_st;
  logic [SVW-1:0]                res_found;
  logic [KB-1:0]                 res_ekey;
  logic [SVW-1:0]                res_eval;

  logic          v1, v2, hit1, hit2, rd_v;
  logic [KB-1:0] rd_key;
  logic [SVW-1:0] rd_val, d1_val, d2_val;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q <= ckh_pkg::CFG_RESET;
    end else if (cfg_valid) begin
      cfg_q <= cfg_data;
    end
  end

  // Clamp the size to the supported range
  always_comb begin
    if (cfg_q < 4'd2) lg = LGW'(2);
    else if (32'(cfg_q) > TABLE_LOG_MAX) lg = LGW'(TABLE_LOG_MAX);
    else lg = LGW'(cfg_q);
  end

  // Slot indices from the top bits of the registered products
  assign fval = {hkey[KB-2:0], 1'b1};
  assign h1 = IW'(pa[31 -: IW] >> (LGW'(TABLE_LOG_MAX) - lg));
  assign h2 = IW'(pb[31 -: IW] >> (LGW'(TABLE_LOG_MAX) - lg));

  // Slot word fields
  assign v1     = d1[WW-1];
  assign v2     = rdata[WW-1];
  assign rd_v   = rdata[WW-1];
  assign rd_key = rdata[WW-2 -: KB];
  assign rd_val = rdata[SVW-1:0];
  assign d1_val = d1[SVW-1:0];
  assign d2_val = rdata[SVW-1:0];
  assign hit1   = v1 && (d1[WW-2 -: KB] == key);
  assign hit2   = v2 && (rd_key == key);

  // Status to the sequencer
  always_comb begin
    stat.cmd        = cmd;
    stat.evict_need = (cmd == ckh_pkg::CMD_INSERT) && v1 && v2 && !hit1 && !hit2;
    stat.kick_free  = !rd_v;
    stat.kicks_zero = (kicks == '0);
    stat.clr_last   = (clr_idx == IW'(SLOTS - 1));
    stat.out_full   = out_valid && !out_ready;
  end

  // Memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = pos;
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_word = {1'b1, ck, cv};
    unique case (op)
      ckh_pkg::DP_RD1: begin
        rd_en = 1'b1;
        rd_addr = h1;
      end
      ckh_pkg::DP_RD2: begin
        rd_en = 1'b1;
        rd_addr = h2;
      end
      ckh_pkg::DP_KRD: rd_en = 1'b1;
      ckh_pkg::DP_DECIDE: begin
        if (cmd == ckh_pkg::CMD_INSERT) begin
          wr_word = {1'b1, key, val};
          priority if (hit1) begin
            wr_en = 1'b1;
            wr_addr = h1;
          end else if (hit2) begin
            wr_en = 1'b1;
            wr_addr = h2;
          end else if (!v1) begin
            wr_en = 1'b1;
            wr_addr = h1;
          end else if (!v2) begin
            wr_en = 1'b1;
            wr_addr = h2;
          end
        end else if (cmd == ckh_pkg::CMD_ERASE) begin
          wr_word = '0;
          priority if (hit1) begin
            wr_en = 1'b1;
            wr_addr = h1;
          end else if (hit2) begin
            wr_en = 1'b1;
            wr_addr = h2;
          end
        end
      end
      ckh_pkg::DP_KCHK: wr_en = !rd_v || (kicks != '0);
      ckh_pkg::DP_CLR: begin
        wr_en = 1'b1;
        wr_addr = clr_idx;
        wr_word = '0;
      end
      default: rd_en = 1'b0;
    endcase
  end

  // Slot memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_word;
    if (rd_en) rdata <= mem[rd_addr];
  end

  // Clear sweep index
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (op == ckh_pkg::DP_CLR) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case (op)
        ckh_pkg::DP_DECIDE: begin
          if (cmd == ckh_pkg::CMD_INSERT && !hit1 && !hit2 && (!v1 || !v2)) begin
            count <= count + 1'b1;
          end else if (cmd == ckh_pkg::CMD_ERASE && (hit1 || hit2) && count != '0) begin
            count <= count - 1'b1;
          end
        end
        ckh_pkg::DP_KCHK: if (!rd_v) count <= count + 1'b1;
        ckh_pkg::DP_CLR_DONE: count <= '0;
        default: count <= count;
      endcase
    end
  end

  // Request, hash and eviction chain registers
  always_ff @(posedge clk) begin
    unique case (op)
      ckh_pkg::DP_ACCEPT: begin
        cmd  <= in_cmd;
        key  <= in_key;
        val  <= in_value[SVW-1:0];
        hkey <= in_key;
      end
      ckh_pkg::DP_HASH: begin
        pa <= fval * ckh_pkg::MUL_A;
        pb <= fval * ckh_pkg::MUL_B;
      end
      ckh_pkg::DP_RD2: d1 <= rdata;
      ckh_pkg::DP_DECIDE: begin
        pos   <= h1;
        kicks <= count;
        ck    <= key;
        cv    <= val;
      end
      ckh_pkg::DP_KCHK: begin
        if (rd_v && kicks != '0) begin
          ck    <= rd_key;
          cv    <= rd_val;
          hkey  <= rd_key;
          kicks <= kicks - 1'b1;
        end
      end
      ckh_pkg::DP_KPOS: pos <= pos ^ h1 ^ h2;
      default: pos <= pos;
    endcase
  end

  // Result of the request
  always_ff @(posedge clk) begin
    unique case (op)
      ckh_pkg::DP_DECIDE: begin
        res_ekey <= '0;
        res_eval <= '0;
        if (cmd == ckh_pkg::CMD_INSERT) begin
          res_st    <= (hit1 || hit2) ? ckh_pkg::ST_UPDATED : ckh_pkg::ST_NEW;
          res_found <= '0;
        end else if (cmd == ckh_pkg::CMD_LOOKUP && hit1) begin
          res_st    <= ckh_pkg::ST_FOUND;
          res_found <= d1_val;
        end else if (cmd == ckh_pkg::CMD_LOOKUP && hit2) begin
          res_st    <= ckh_pkg::ST_FOUND;
          res_found <= d2_val;
        end else if (cmd == ckh_pkg::CMD_ERASE && (hit1 || hit2)) begin
          res_st    <= ckh_pkg::ST_ERASED;
          res_found <= '0;
        end else begin
          res_st    <= ckh_pkg::ST_NOT_FOUND;
          res_found <= '0;
        end
      end
      ckh_pkg::DP_KCHK: begin
        if (rd_v && kicks == '0) begin
          res_st   <= ckh_pkg::ST_FULL;
          res_ekey <= ck;
          res_eval <= cv;
        end
      end
      ckh_pkg::DP_CLR_DONE: begin
        res_st    <= ckh_pkg::ST_CLEARED;
        res_found <= '0;
        res_ekey  <= '0;
        res_eval  <= '0;
      end
      default: res_st <= res_st;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == ckh_pkg::DP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == ckh_pkg::DP_EMIT) begin
      out_status <= res_st;
      out_found  <= ckh_pkg::DATA_BITS'(res_found);
      out_ekey   <= res_ekey;
      out_evalue <= ckh_pkg::DATA_BITS'(res_eval);
      out_count  <= ckh_pkg::CNT_BITS'(count);
    end
  end

endmodule

// ===== hw/rtl/cuckoo_hash_table.sv =====
// Top level of the cuckoo hash table: sequencer, datapath and checks.
//
//   channel  | dir | handshake            | payload
//   s_*      | in  | s_tvalid / s_tready  | tuser: cmd; tdata: key, value
//   m_*      | out | m_tvalid / m_tready  | tuser: status; tdata: results
//   cfg_*    | in  | cfg_valid / cfg_ready| cfg_data: table_size_log
//
// Lookup, erase and a direct insert pass from accept to result through these steps:
// hash multiply, two reads of the single-read-port slot memory, decide, emit.
// Each eviction kick adds the steps read, write-back, rehash and next slot, and
// the final placement or full check adds a read and a write-back.
// Clear sweeps the memory one slot a cycle.
// After reset the same sweep runs with s_tready low.
// A result waits in the output register while m_tready is low; the next
// request is taken meanwhile and holds in its last step until the register frees.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cuckoo_hash_table #(
  parameter int TABLE_LOG_MAX = ckh_pkg::TABLE_LOG_MAX_DEF,
  parameter int VALUE_BITS    = ckh_pkg::VALUE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // key [31:0], value [63:32]
  input  logic [1:0]   s_tuser,   // cmd [1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,   // found_value, evicted_key, evicted_value, entry_count
  output logic [2:0]   m_tuser,   // status [2:0]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [ckh_pkg::CFG_BITS-1:0] cfg_data
);

  ckh_pkg::dp_op_t   op;
  ckh_pkg::dp_stat_t stat;

  logic [ckh_pkg::DATA_BITS-1:0] found_value, evicted_value;
  logic [ckh_pkg::KEY_BITS-1:0]  evicted_key;
  logic [ckh_pkg::CNT_BITS-1:0]  entry_count;

  assign cfg_ready = 1'b1;

  ckh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .op       (op)
  );

  ckh_datapath #(
    .TABLE_LOG_MAX (TABLE_LOG_MAX),
    .VALUE_BITS    (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_cmd     (s_tuser),
    .in_key     (s_tdata[31:0]),
    .in_value   (s_tdata[63:32]),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .op         (op),
    .stat       (stat),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_found  (found_value),
    .out_ekey   (evicted_key),
    .out_evalue (evicted_value),
    .out_count  (entry_count)
  );

  // Pack the result fields, lowest first, padded to whole bytes
  assign m_tdata = {5'b0, entry_count, evicted_value, evicted_key, found_value};

  // Checks
  `ASSERT_IMPLIES(a_clear_empties, clk, rst,
    m_tvalid && m_tuser == ckh_pkg::ST_CLEARED, entry_count == '0)
  `ASSERT_IMPLIES(a_evict_only_full, clk, rst,
    m_tvalid && m_tuser != ckh_pkg::ST_FULL, evicted_key == '0 && evicted_value == '0)
  `ASSERT_IMPLIES(a_count_bound, clk, rst,
    m_tvalid, 32'(entry_count) <= (1 << TABLE_LOG_MAX))
  `ASSERT_NEXT(a_one_at_a_time, clk, rst,
    s_tvalid && s_tready, !s_tready)

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the cuckoo hash table: hash-map predictor, checker, test tasks.
`timescale 1ns / 1ps
module tb;

  localparam int SLOTS = 1 << ckh_pkg::TABLE_LOG_MAX_DEF;
  localparam int QUIET_LIMIT = 200000;

  typedef struct packed {
    logic [ckh_pkg::STAT_BITS-1:0] status;
    logic [31:0] found_value;
    logic [31:0] evicted_key;
    logic [31:0] evicted_value;
    logic [ckh_pkg::CNT_BITS-1:0] entry_count;
  } map_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;   // key [31:0], value [63:32]
  logic [1:0] s_tuser = '0;    // cmd [1:0]
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [111:0] m_tdata;       // found_value, evicted_key, evicted_value, entry_count
  logic [2:0] m_tuser;         // status [2:0]
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ckh_pkg::CFG_BITS-1:0] cfg_data = '0;

  cuckoo_hash_table dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: the shadow table
  logic [31:0] shadow_keys [SLOTS];
  logic [31:0] shadow_vals [SLOTS];
  logic shadow_used [SLOTS];
  int unsigned shadow_count;
  logic [ckh_pkg::CFG_BITS-1:0] size_log_reg;
  map_result_t pending_results[$];
  logic [31:0] key_pool[$];

  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_full = 0;
  int n_kicked = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  function automatic int unsigned live_log();
    if (size_log_reg < 2) return 2;
    if (size_log_reg > ckh_pkg::TABLE_LOG_MAX_DEF) return ckh_pkg::TABLE_LOG_MAX_DEF;
    return 32'(size_log_reg);
  endfunction

  function automatic void slot_pair(input logic [31:0] k, output int unsigned a,
                                    output int unsigned b);
    logic [31:0] f;
    logic [31:0] pa;
    logic [31:0] pb;
    f = {k[30:0], 1'b1};
    pa = f * ckh_pkg::MUL_A;
    pb = f * ckh_pkg::MUL_B;
    a = pa >> (32 - live_log());
    b = pb >> (32 - live_log());
  endfunction

  function automatic bit slot_has(int unsigned i, logic [31:0] k);
    return shadow_used[i] && shadow_keys[i] == k;
  endfunction

  // Apply one request to the shadow table and return what the block must report
  function automatic map_result_t apply_request(logic [1:0] cmd, logic [31:0] k,
                                                logic [31:0] v);
    map_result_t r;
    int unsigned h1, h2, pos, a, b, kicks, mask;
    logic [31:0] ck, cv, tk, tv;
    r = '0;
    r.status = ckh_pkg::ST_NOT_FOUND;
    slot_pair(k, h1, h2);
    case (cmd)
      ckh_pkg::CMD_INSERT: begin
        if (slot_has(h1, k)) begin
          shadow_vals[h1] = v; r.status = ckh_pkg::ST_UPDATED;
        end else if (slot_has(h2, k)) begin
          shadow_vals[h2] = v; r.status = ckh_pkg::ST_UPDATED;
        end else if (!shadow_used[h1]) begin
          shadow_keys[h1] = k; shadow_vals[h1] = v; shadow_used[h1] = 1;
          shadow_count++; r.status = ckh_pkg::ST_NEW;
        end else if (!shadow_used[h2]) begin
          shadow_keys[h2] = k; shadow_vals[h2] = v; shadow_used[h2] = 1;
          shadow_count++; r.status = ckh_pkg::ST_NEW;
        end else begin
          // walk the eviction chain
          n_kicked++;
          mask = (1 << live_log()) - 1;
          pos = h1; kicks = shadow_count; ck = k; cv = v;
          r.status = ckh_pkg::ST_NEW;
          while (shadow_used[pos]) begin
            if (kicks == 0) begin
              r.status = ckh_pkg::ST_FULL;
              break;
            end
            kicks--;
            tk = shadow_keys[pos]; tv = shadow_vals[pos];
            shadow_keys[pos] = ck; shadow_vals[pos] = cv;
            ck = tk; cv = tv;
            slot_pair(ck, a, b);
            pos = (pos ^ a ^ b) & mask;
          end
          if (r.status == ckh_pkg::ST_FULL) begin
            r.evicted_key = ck; r.evicted_value = cv; n_full++;
          end else begin
            shadow_keys[pos] = ck; shadow_vals[pos] = cv; shadow_used[pos] = 1;
            shadow_count++;
          end
        end
      end
      ckh_pkg::CMD_LOOKUP: begin
        if (slot_has(h1, k)) begin
          r.status = ckh_pkg::ST_FOUND; r.found_value = shadow_vals[h1];
        end else if (slot_has(h2, k)) begin
          r.status = ckh_pkg::ST_FOUND; r.found_value = shadow_vals[h2];
        end
      end
      ckh_pkg::CMD_ERASE: begin
        pos = SLOTS;
        if (slot_has(h1, k)) pos = h1;
        else if (slot_has(h2, k)) pos = h2;
        if (pos < SLOTS) begin
          shadow_used[pos] = 0;
          if (shadow_count > 0) shadow_count--;
          r.status = ckh_pkg::ST_ERASED;
        end
      end
      default: begin
        foreach (shadow_used[i]) shadow_used[i] = 0;
        shadow_count = 0;
        r.status = ckh_pkg::ST_CLEARED;
      end
    endcase
    r.entry_count = ckh_pkg::CNT_BITS'(shadow_count);
    return r;
  endfunction

  // Send one request, predicting its result at acceptance
  task automatic send_request(logic [1:0] cmd, logic [31:0] k, logic [31:0] v);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
      @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser = cmd;
    s_tdata = {v, k};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(apply_request(cmd, k, v));
    if (cmd == ckh_pkg::CMD_INSERT && key_pool.size() < 64) key_pool.push_back(k);
    n_sent++;
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // Write the size register while idle
  task automatic write_size(logic [ckh_pkg::CFG_BITS-1:0] lg);
    wait_drained();
    repeat (SLOTS + 20) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= lg;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    size_log_reg = lg;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_key();
    if (key_pool.size() != 0 && $urandom_range(3, 0) != 0)
      return key_pool[$urandom_range(key_pool.size() - 1, 0)];
    return $urandom();
  endfunction

  // Check each result against the oldest prediction
  always @(posedge clk) begin
    map_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.status        = m_tuser;
      got.found_value   = m_tdata[31:0];
      got.evicted_key   = m_tdata[63:32];
      got.evicted_value = m_tdata[95:64];
      got.entry_count   = m_tdata[106:96];
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (got.status !== want.status)
          $display("%0t status exp %0d got %0d", $time, want.status, got.status);
        if (got.found_value !== want.found_value)
          $display("%0t found_value exp %h got %h", $time, want.found_value,
                   got.found_value);
        if (got.evicted_key !== want.evicted_key)
          $display("%0t evicted_key exp %h got %h", $time, want.evicted_key,
                   got.evicted_key);
        if (got.evicted_value !== want.evicted_value)
          $display("%0t evicted_value exp %h got %h", $time, want.evicted_value,
                   got.evicted_value);
        if (got.entry_count !== want.entry_count)
          $display("%0t entry_count exp %0d got %0d", $time, want.entry_count,
                   got.entry_count);
        if (got !== want) errors++;
      end
    end
  end

  // Drive receiver stalls
  always @(negedge clk) begin
    m_tready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
  end

  // Watchdog on cycles with no traffic
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[cuckoo_hash_table] ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(ckh_pkg::CMD_LOOKUP, 32'h0, 32'h0);
    send_request(ckh_pkg::CMD_ERASE, 32'hFFFF_FFFF, 32'h0);
    send_request(ckh_pkg::CMD_INSERT, 32'h0, 32'hFFFF_FFFF);
    send_request(ckh_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'h0);
    send_request(ckh_pkg::CMD_INSERT, 32'h0, 32'h1234_5678);
    send_request(ckh_pkg::CMD_LOOKUP, 32'h0, 32'h0);
    send_request(ckh_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(ckh_pkg::CMD_ERASE, 32'h0, 32'h0);
    send_request(ckh_pkg::CMD_LOOKUP, 32'h0, 32'h0);
    send_request(ckh_pkg::CMD_CLEAR, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_request(ckh_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0);
  endtask

  // Fill a table of the given size; on the small sizes this goes past capacity to force chains and full reports
  task automatic test_small_table(logic [ckh_pkg::CFG_BITS-1:0] lg, int n);
    write_size(lg);
    send_request(ckh_pkg::CMD_CLEAR, 0, 0);
    for (int i = 0; i < n; i++) send_request(ckh_pkg::CMD_INSERT, $urandom(), $urandom());
    for (int i = 0; i < 6; i++) send_request(ckh_pkg::CMD_LOOKUP, pick_key(), 0);
  endtask

  // Mixed random traffic over a small key pool
  task automatic test_random(int n, int pool);
    logic [1:0] cmd;
    int unsigned roll;
    key_pool.delete();
    for (int i = 0; i < pool; i++) key_pool.push_back($urandom());
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99, 0);
      cmd = roll < 50 ? ckh_pkg::CMD_INSERT : roll < 78 ? ckh_pkg::CMD_LOOKUP
          : roll < 98 ? ckh_pkg::CMD_ERASE : ckh_pkg::CMD_CLEAR;
      send_request(cmd, pick_key(), $urandom());
    end
  endtask

  initial begin
    foreach (shadow_used[i]) shadow_used[i] = 0;
    shadow_count = 0;
    size_log_reg = ckh_pkg::CFG_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_small_table(4'd2, 10);
    test_small_table(4'd0, 8);
    test_small_table(4'd15, 12);
    test_small_table(4'd3, 14);
    write_size(4'd4);
    test_random(300, 24);
    send_idle_pct = 62;
    test_random(200, 24);
    wait_drained();        // sender holds until every result is back
    send_idle_pct = 0; recv_stall_pct = 62;
    write_size(4'd6);
    test_random(250, 80);
    send_idle_pct = 8; recv_stall_pct = 8;
    write_size(4'd10);
    test_random(200, 300);
    send_idle_pct = 0; recv_stall_pct = 0;
    write_size(4'd5);
    test_random(100, 40);

    wait_drained();
    $display("Ran %0d requests, %0d results checked, %0d eviction chains, %0d full.",
             n_sent, n_checked, n_kicked, n_full);
    $display("Table sizes 2 to 10 slots-log, including out-of-range register values.");
    if (errors == 0) begin
      $display("[cuckoo_hash_table] OK");
    end else begin
      $display("[cuckoo_hash_table] ERROR");
    end
    $finish;
  end
endmodule

// ===== cuckoo_hash_table.f =====
+incdir+hw/rtl
hw/rtl/ckh_pkg.sv
hw/rtl/ckh_ctrl.sv
hw/rtl/ckh_datapath.sv
hw/rtl/cuckoo_hash_table.sv
bench/tb.sv
